>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is high.
`define NWU_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");

// Concurrent check that also runs through reset.
`define NWU_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");

`endif

>>> rtl/core/nwu_pkg.sv
// Shared types and constants of the normalised int8 weight-update block.
package nwu_pkg;

  localparam int LANES_DEF  = 10;
  localparam int NORM_SHIFT = 7;
  localparam int NORM_PEAK  = (2 ** NORM_SHIFT) - 1;
  localparam int FRAC_BITS  = 28;
  localparam int LR_SHIFT   = 16;

  localparam int PROD_W    = 16;
  localparam int MAG_W     = 15;
  localparam int MUL_A_W   = 23;
  localparam int MUL_B_W   = 18;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 57;
  localparam int DVD_W     = ACC_W - FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  localparam int POS_LIMIT = 127;
  localparam int NEG_LIMIT = 128;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [7:0] CLAMP_LOW_RST  = -8'sd128;
  localparam logic signed [7:0] CLAMP_HIGH_RST = 8'sd127;
  localparam logic [15:0]       LEARN_RATE_RST = 16'd655;
  localparam logic signed [7:0] W_MAX          = 8'sd127;
  localparam logic signed [7:0] W_MIN          = -8'sd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLAMP_LOW  = 2'd0,
    CFG_CLAMP_HIGH = 2'd1,
    CFG_LEARN_RATE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [7:0] activation;
    logic signed [7:0] gradient;
    logic signed [7:0] weight_in;
    logic [15:0]       channel_scale;
    logic              block_end;
  } item_t;

  typedef struct packed {
    logic signed [7:0] weight_out;
    logic              run_last;
    logic              saturated;
  } result_t;

endpackage

>>> rtl/core/normalized_int8_weight_update.sv
// Top level of the normalised int8 weight-update block.
//
// Input: a transaction is taken at a clock edge with start high and busy low.
// Each transaction is one lane: activation, gradient, current weight, scale
// and a block_end flag. A lane that does not end the block is stored and
// busy stays low, so lanes may arrive back to back.
// A lane with block_end set, or the lane that fills the last buffer slot,
// closes the block: busy rises and one result per stored lane follows, in
// lane order, each shown for a single cycle with result_valid high; run_last
// marks the final one. The receiver cannot stall, so results are never held.
// Steps: each lane of a closed block takes its products on the shared
// multiplier, one magnitude step, then the one-bit-per-cycle divider; a lane
// passes its weight through when every product of the block was zero.
// busy drops in the cycle after the last result.
// Configuration: cfg_we writes clamp_low (index 0), clamp_high (index 1) or
// learn_rate (index 2) at once; other indexes are ignored. Write only while
// busy is low. Reset returns the registers to their defaults and empties the
// lane buffer; no clearing pass is needed.
module normalized_int8_weight_update #(
  parameter int LANES = nwu_pkg::LANES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  nwu_pkg::item_t                    item,
  output logic                              result_valid,
  output nwu_pkg::result_t                  result,
  input  logic                              cfg_we,
  input  logic [nwu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nwu_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CNT_W  = $clog2(LANES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_LO, S_HI, S_SR, S_NL, S_NH, S_WM, S_ACC, S_ABS, S_DIV
  } state_t;

  state_t state;

  logic signed [7:0] clamp_low;
  logic signed [7:0] clamp_high;
  logic [15:0]       learn_rate;

  logic signed [nwu_pkg::PROD_W-1:0] product_buf [LANES];
  logic signed [7:0]                 weight_buf  [LANES];
  logic [15:0]                       scale_buf   [LANES];

  logic [nwu_pkg::MAG_W-1:0] max_abs;
  logic [CNT_W-1:0]          lane_count;
  logic [CNT_W-1:0]          emit_lane;

  logic signed [7:0]                  cur_w;
  logic [15:0]                        cur_s;
  logic signed [nwu_pkg::MUL_A_W-1:0] norm;
  logic [15:0]                        sr_high;
  logic signed [nwu_pkg::ACC_W-1:0]   acc;
  logic                               neg;

  logic                              accept;
  logic                              block_close;
  logic [LANE_W-1:0]                 wr_idx;
  logic [LANE_W-1:0]                 rd_idx;
  logic signed [nwu_pkg::PROD_W-1:0] item_product;
  logic [nwu_pkg::PROD_W-1:0]        item_abs;
  logic signed [nwu_pkg::PROD_W-1:0] rd_product;

  logic signed [nwu_pkg::MUL_A_W-1:0] mul_a;
  logic signed [nwu_pkg::MUL_B_W-1:0] mul_b;
  logic signed [nwu_pkg::MUL_P_W-1:0] mul_p;

  logic [nwu_pkg::ACC_W-1:0] acc_mag;
  logic                      div_start;
  logic                      div_done;
  logic [nwu_pkg::DVD_W-1:0] div_quot;

  logic              emit;
  logic              emit_last;
  logic signed [7:0] emit_w;
  logic              emit_sat;

  // hold busy through the cycle that shows the last result
  assign busy         = (state != S_IDLE) || result_valid;
  assign accept       = start && !busy;
  assign wr_idx       = lane_count[LANE_W-1:0];
  assign rd_idx       = emit_lane[LANE_W-1:0];
  assign rd_product   = product_buf[rd_idx];
  assign item_product = item.activation * item.gradient;
  assign item_abs     = item_product[nwu_pkg::PROD_W-1] ? -item_product : item_product;
  assign block_close  = item.block_end || (lane_count == CNT_W'(LANES - 1));
  assign emit_last    = ((emit_lane + CNT_W'(1)) == lane_count);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_low  <= nwu_pkg::CLAMP_LOW_RST;
      clamp_high <= nwu_pkg::CLAMP_HIGH_RST;
      learn_rate <= nwu_pkg::LEARN_RATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        nwu_pkg::CFG_CLAMP_LOW:  clamp_low  <= cfg_data[7:0];
        nwu_pkg::CFG_CLAMP_HIGH: clamp_high <= cfg_data[7:0];
        nwu_pkg::CFG_LEARN_RATE: learn_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // lane buffer
  always_ff @(posedge clk) begin
    if (accept) begin
      product_buf[wr_idx] <= item_product;
      weight_buf[wr_idx]  <= item.weight_in;
      scale_buf[wr_idx]   <= item.channel_scale;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_LO: begin
        mul_a = nwu_pkg::MUL_A_W'(clamp_low);
        mul_b = nwu_pkg::MUL_B_W'(max_abs);
      end
      S_HI: begin
        mul_a = nwu_pkg::MUL_A_W'(clamp_high);
        mul_b = nwu_pkg::MUL_B_W'(max_abs);
      end
      S_SR: begin
        mul_a = nwu_pkg::MUL_A_W'(cur_s);
        mul_b = nwu_pkg::MUL_B_W'(learn_rate);
      end
      S_NL: begin
        mul_a = norm;
        mul_b = nwu_pkg::MUL_B_W'(mul_p[nwu_pkg::LR_SHIFT-1:0]);
      end
      S_NH: begin
        mul_a = norm;
        mul_b = nwu_pkg::MUL_B_W'(sr_high);
      end
      S_WM: begin
        mul_a = nwu_pkg::MUL_A_W'(cur_w);
        mul_b = nwu_pkg::MUL_B_W'(max_abs);
      end
      default: ;
    endcase
  end

  nwu_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign acc_mag   = acc[nwu_pkg::ACC_W-1] ? nwu_pkg::ACC_W'(-acc) : nwu_pkg::ACC_W'(acc);
  assign div_start = (state == S_ABS);

  nwu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_mag[nwu_pkg::ACC_W-1:nwu_pkg::FRAC_BITS]),
    .divisor  (max_abs),
    .done     (div_done),
    .quotient (div_quot)
  );

  // result of the lane in flight, with int8 saturation
  always_comb begin
    emit     = 1'b0;
    emit_w   = cur_w;
    emit_sat = 1'b0;
    case (state)
      S_LOAD: begin
        if (max_abs == '0) begin
          emit   = 1'b1;
          emit_w = weight_buf[rd_idx];
        end
      end
      S_DIV: begin
        if (div_done) begin
          emit = 1'b1;
          if (!neg && (div_quot > nwu_pkg::DVD_W'(nwu_pkg::POS_LIMIT))) begin
            emit_w   = nwu_pkg::W_MAX;
            emit_sat = 1'b1;
          end else if (neg && (div_quot > nwu_pkg::DVD_W'(nwu_pkg::NEG_LIMIT))) begin
            emit_w   = nwu_pkg::W_MIN;
            emit_sat = 1'b1;
          end else if (neg) begin
            emit_w = 8'(-div_quot[7:0]);
          end else begin
            emit_w = div_quot[7:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      lane_count   <= '0;
      max_abs      <= '0;
      emit_lane    <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
      case (state)
        S_IDLE: begin
          if (accept) begin
            lane_count <= lane_count + CNT_W'(1);
            if (item_abs[nwu_pkg::MAG_W-1:0] > max_abs) begin
              max_abs <= item_abs[nwu_pkg::MAG_W-1:0];
            end
            if (block_close) begin
              emit_lane <= '0;
              state     <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          cur_w <= weight_buf[rd_idx];
          cur_s <= scale_buf[rd_idx];
          // product * 127 as (p << 7) - p
          norm  <= (nwu_pkg::MUL_A_W'(rd_product) <<< nwu_pkg::NORM_SHIFT)
                   - nwu_pkg::MUL_A_W'(rd_product);
          if (max_abs != '0) begin
            state <= S_LO;
          end
        end
        S_LO: state <= S_HI;
        S_HI: begin
          if (mul_p > nwu_pkg::MUL_P_W'(norm)) begin
            norm <= nwu_pkg::MUL_A_W'(mul_p);
          end
          state <= S_SR;
        end
        S_SR: begin
          // upper clamp last, so it wins on inverted bounds
          if (nwu_pkg::MUL_P_W'(norm) > mul_p) begin
            norm <= nwu_pkg::MUL_A_W'(mul_p);
          end
          state <= S_NL;
        end
        S_NL: begin
          sr_high <= mul_p[2*nwu_pkg::LR_SHIFT-1:nwu_pkg::LR_SHIFT];
          state   <= S_NH;
        end
        S_NH: begin
          acc   <= -nwu_pkg::ACC_W'(mul_p);
          state <= S_WM;
        end
        S_WM: begin
          acc   <= acc - (nwu_pkg::ACC_W'(mul_p) <<< nwu_pkg::LR_SHIFT);
          state <= S_ACC;
        end
        S_ACC: begin
          acc   <= acc + (nwu_pkg::ACC_W'(mul_p) <<< nwu_pkg::FRAC_BITS);
          state <= S_ABS;
        end
        S_ABS: begin
          neg   <= acc[nwu_pkg::ACC_W-1];
          state <= S_DIV;
        end
        S_DIV: ;
        default: state <= S_IDLE;
      endcase
      if (emit) begin
        result.weight_out <= emit_w;
        result.saturated  <= emit_sat;
        result.run_last   <= emit_last;
        // advance to the next lane, or drop the block once the last is out
        if (emit_last) begin
          state      <= S_IDLE;
          lane_count <= '0;
          max_abs    <= '0;
        end else begin
          emit_lane <= emit_lane + CNT_W'(1);
          state     <= S_LOAD;
        end
      end
    end
  end

endmodule

>>> rtl/core/nwu_mul.sv
// Shared signed multiplier with a registered product.
module nwu_mul (
  input  logic                                clk,
  input  logic signed [nwu_pkg::MUL_A_W-1:0] a,
  input  logic signed [nwu_pkg::MUL_B_W-1:0] b,
  output logic signed [nwu_pkg::MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> rtl/core/nwu_div.sv
// Restoring divider, one quotient bit per cycle.
module nwu_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [nwu_pkg::DVD_W-1:0]        dividend,
  input  logic [nwu_pkg::MAG_W-1:0]        divisor,
  output logic                             done,
  output logic [nwu_pkg::DVD_W-1:0]        quotient
);

  logic [nwu_pkg::DIV_CNT_W-1:0] count;
  logic [nwu_pkg::MAG_W-1:0]     rem;
  logic [nwu_pkg::MAG_W-1:0]     dsr;
  logic [nwu_pkg::DVD_W-1:0]     quo;
  logic [nwu_pkg::MAG_W+1:0]     trial;
  logic [nwu_pkg::MAG_W:0]       shifted;

  assign shifted = {rem, quo[nwu_pkg::DVD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (count == nwu_pkg::DIV_CNT_W'(1));
      if (start) begin
        count <= nwu_pkg::DIV_CNT_W'(nwu_pkg::DVD_W);
        rem   <= '0;
        dsr   <= divisor;
        quo   <= dividend;
      end else if (count != '0) begin
        count <= count - nwu_pkg::DIV_CNT_W'(1);
        // keep the trial difference unless it borrowed
        if (!trial[nwu_pkg::MAG_W+1]) begin
          rem <= trial[nwu_pkg::MAG_W-1:0];
        end else begin
          rem <= shifted[nwu_pkg::MAG_W-1:0];
        end
        quo <= {quo[nwu_pkg::DVD_W-2:0], ~trial[nwu_pkg::MAG_W+1]};
      end
    end
  end

  assign quotient = quo;

endmodule

>>> rtl/core/nwu_checker.sv
// Port-level checks of the weight-update block and their binding.
`include "assert_macros.svh"

module nwu_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input nwu_pkg::item_t   item,
  input logic             result_valid,
  input nwu_pkg::result_t result
);

  `NWU_ASSERT(a_result_only_busy, clk, rst, result_valid |-> busy)
  `NWU_ASSERT(a_block_end_busy, clk, rst, (start && !busy && item.block_end) |=> busy)
  `NWU_ASSERT(a_last_frees, clk, rst, (result_valid && result.run_last) |=> (!busy && !result_valid))
  `NWU_ASSERT_NR(a_reset_idle, clk, rst |=> (!busy && !result_valid))

endmodule

bind normalized_int8_weight_update nwu_checker u_nwu_checker (.*);

>>> test/tb.sv
// Self-checking testbench for the normalised int8 weight-update block.
module tb;
  import nwu_pkg::*;

  localparam int NUM_LANES   = LANES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 270;
  localparam int SETTLE_CYCLES = 45;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  item_t                 item;
  logic                  result_valid;
  result_t               result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  normalized_int8_weight_update u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Own copy of the block's lane buffer and registers.
  int lane_prod [NUM_LANES];
  int lane_wt   [NUM_LANES];
  int lane_scl  [NUM_LANES];
  int peak_mag;
  int lane_cnt;
  int clamp_lo;
  int clamp_hi;
  int learn_rt;

  result_t pending_weights[$];
  int      fail_count;
  int      cycle_count;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("normalized_int8_weight_update: mismatch");
      $finish;
    end
  end

  // Compare each result transaction with the oldest predicted weight.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (pending_weights.size() == 0) begin
        $display("%0t: unexpected result: actual w=%0d last=%0b sat=%0b", $time,
                 result.weight_out, result.run_last, result.saturated);
        fail_count++;
      end else begin
        want = pending_weights.pop_front();
        if (result.weight_out !== want.weight_out || result.run_last !== want.run_last ||
            result.saturated !== want.saturated) begin
          $display("%0t: expected w=%0d last=%0b sat=%0b, actual w=%0d last=%0b sat=%0b",
                   $time, want.weight_out, want.run_last, want.saturated,
                   result.weight_out, result.run_last, result.saturated);
          fail_count++;
        end
      end
    end
  end

  function automatic result_t lane_update(input int prod, input int wt, input int scl);
    longint m, n, lo, hi, den, x, q;
    result_t r;
    m = peak_mag;
    r.run_last  = 1'b0;
    r.saturated = 1'b0;
    if (m == 0) begin
      q = wt;
    end else begin
      n  = longint'(prod) * NORM_PEAK;
      lo = longint'(clamp_lo) * m;
      hi = longint'(clamp_hi) * m;
      // upper bound applied last, so it wins when the bounds cross
      if (n < lo) n = lo;
      if (n > hi) n = hi;
      den = m * (64'sd1 <<< FRAC_BITS);
      x = longint'(wt) * den - n * longint'(scl) * longint'(learn_rt);
      q = x / den;
    end
    if (q > 127) begin
      q = 127;
      r.saturated = 1'b1;
    end else if (q < -128) begin
      q = -128;
      r.saturated = 1'b1;
    end
    r.weight_out = q[7:0];
    return r;
  endfunction

  // Store one accepted lane; on block close, queue one weight per lane.
  task automatic predict_lane(input item_t it);
    int a, g, p, k;
    result_t r;
    a = $signed(it.activation);
    g = $signed(it.gradient);
    p = a * g;
    lane_prod[lane_cnt] = p;
    lane_wt[lane_cnt]   = $signed(it.weight_in);
    lane_scl[lane_cnt]  = it.channel_scale;
    if ((p < 0 ? -p : p) > peak_mag) peak_mag = (p < 0 ? -p : p);
    lane_cnt++;
    if (it.block_end || lane_cnt == NUM_LANES) begin
      for (k = 0; k < lane_cnt; k++) begin
        r = lane_update(lane_prod[k], lane_wt[k], lane_scl[k]);
        r.run_last = (k == lane_cnt - 1);
        pending_weights.push_back(r);
      end
      lane_cnt = 0;
      peak_mag = 0;
    end
  endtask

  task automatic send_lane(input item_t it, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item  = it;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_lane(it);
  endtask

  // Drop start and hold until every expected weight is out and busy is low.
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    wait_idle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    case (idx)
      CFG_CLAMP_LOW: begin
        cfg_data = {8'h00, value[7:0]};
        clamp_lo = $signed(value[7:0]);
      end
      CFG_CLAMP_HIGH: begin
        cfg_data = {8'h00, value[7:0]};
        clamp_hi = $signed(value[7:0]);
      end
      CFG_LEARN_RATE: begin
        cfg_data = value[15:0];
        learn_rt = value[15:0];
      end
      default: cfg_data = value[15:0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic item_t lane(input int a, input int g, input int w, input int s,
                                 input bit e);
    item_t it;
    it.activation    = a[7:0];
    it.gradient      = g[7:0];
    it.weight_in     = w[7:0];
    it.channel_scale = s[15:0];
    it.block_end     = e;
    return it;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h80;
      1: return 8'h7f;
      2: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // One block of len lanes with random content; a full block may omit block_end.
  task automatic run_block(input int len, input bit all_zero);
    item_t it;
    int k;
    bit quiet, no_end;
    quiet  = ($urandom_range(0, 2) == 0);
    no_end = (len == NUM_LANES) && ($urandom_range(0, 1) == 1);
    for (k = 0; k < len; k++) begin
      it.activation    = all_zero ? 8'h00 : pick_byte();
      it.gradient      = pick_byte();
      it.weight_in     = pick_byte();
      it.channel_scale = pick_scale();
      it.block_end     = (k == len - 1) && !no_end;
      send_lane(it, quiet ? 0 : $urandom_range(0, 8));
    end
  endtask

  task automatic test_defaults();
    int k;
    // single lane at the largest magnitude, weight pushed past the negative limit
    send_lane(lane(-128, -128, -128, 65535, 1'b1), 0);
    send_lane(lane(127, -128, 127, 65535, 1'b0), 0);
    send_lane(lane(-128, 127, -128, 0, 1'b0), 0);
    send_lane(lane(1, 1, 127, 65535, 1'b1), 0);
    // every product zero: weights pass through
    send_lane(lane(0, -128, 127, 65535, 1'b0), 0);
    send_lane(lane(127, 0, -128, 65535, 1'b0), 0);
    send_lane(lane(0, 0, 5, 1, 1'b1), 0);
    // fill the buffer without block_end
    for (k = 0; k < NUM_LANES; k++)
      send_lane(lane(k * 28 - 128, 127 - k * 28, 127 - k * 28, 16'hffff >> k, 1'b0),
                $urandom_range(0, 8));
  endtask

  task automatic test_clamp_bounds();
    set_reg(CFG_CLAMP_LOW, 0);
    set_reg(CFG_CLAMP_HIGH, 0);
    run_block(4, 1'b0);
    set_reg(CFG_CLAMP_LOW, -128);
    set_reg(CFG_CLAMP_HIGH, -128);
    set_reg(CFG_LEARN_RATE, 65535);
    run_block(5, 1'b0);
    // crossed bounds
    set_reg(CFG_CLAMP_LOW, 127);
    run_block(3, 1'b0);
    set_reg(CFG_CLAMP_LOW, -128);
    set_reg(CFG_CLAMP_HIGH, 127);
    set_reg(CFG_LEARN_RATE, 0);
    run_block(3, 1'b0);
    set_reg(CFG_CLAMP_LOW, -20);
    set_reg(CFG_CLAMP_HIGH, 100);
    set_reg(CFG_LEARN_RATE, 40000);
    run_block(NUM_LANES, 1'b0);
    // unused index must leave the registers alone
    set_reg(CFG_UNUSED, 16'hffff);
    run_block(2, 1'b0);
  endtask

  task automatic test_idle_drain();
    int k;
    for (k = 0; k < 3; k++) begin
      run_block($urandom_range(1, NUM_LANES), 1'b0);
      wait_idle();
    end
  endtask

  task automatic test_random_blocks();
    int sent, len, sel;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        sel = $urandom_range(0, 3);
        case (sel)
          CFG_CLAMP_LOW, CFG_CLAMP_HIGH: set_reg(sel[CFG_IDX_W-1:0], pick_byte());
          CFG_LEARN_RATE: set_reg(CFG_LEARN_RATE, pick_scale());
          default: set_reg(CFG_UNUSED, $urandom);
        endcase
      end
      if ($urandom_range(0, 9) == 0) wait_idle();
      len = $urandom_range(1, NUM_LANES);
      run_block(len, $urandom_range(0, 11) == 0);
      sent += len;
    end
  endtask

  initial begin
    int k;
    rst         = 1'b1;
    start       = 1'b0;
    item        = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    fail_count  = 0;
    cycle_count = 0;
    for (k = 0; k < NUM_LANES; k++) begin
      lane_prod[k] = 0;
      lane_wt[k]   = 0;
      lane_scl[k]  = 0;
    end
    peak_mag = 0;
    lane_cnt = 0;
    clamp_lo = $signed(CLAMP_LOW_RST);
    clamp_hi = $signed(CLAMP_HIGH_RST);
    learn_rt = LEARN_RATE_RST;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    test_defaults();
    test_clamp_bounds();
    test_idle_drain();
    test_random_blocks();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_weights.size() == 0) begin
      $display("normalized_int8_weight_update: match");
    end else begin
      $display("normalized_int8_weight_update: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/nwu_pkg.sv
rtl/core/nwu_mul.sv
rtl/core/nwu_div.sv
rtl/core/normalized_int8_weight_update.sv
rtl/core/nwu_checker.sv
test/tb.sv
